// File: design/pdrc_pkg.sv
// Shared constants, payload types and control types of the pairwise distance radius counter.
`default_nettype none

package pdrc_pkg;

    localparam int MAX_VECTORS  = 1024;
    localparam int MAX_DIMS     = 16;
    localparam int MAX_RADII    = 64;
    localparam int ELEMENT_BITS = 16;

    localparam int STORE_DEPTH = MAX_VECTORS * MAX_DIMS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int VEC_W       = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int NV_W        = $clog2(MAX_VECTORS + 1);
    localparam int DIM_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int ND_W        = $clog2(MAX_DIMS + 1);
    localparam int RAD_W       = (MAX_RADII > 1) ? $clog2(MAX_RADII) : 1;
    localparam int NR_W        = $clog2(MAX_RADII + 1);

    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 14;
    localparam int RSQ_W      = 40;
    localparam int DIST_W     = 37;
    localparam int COUNT_W    = 19;
    localparam int RIDX_W     = 6;
    localparam int VC_W       = 11;
    localparam int DIMCFG_W   = 5;
    localparam int RCCFG_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DIFF_W     = ELEMENT_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;

    localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_LOAD_ELEM   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_RADIUS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN         = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSION    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_COUNT = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]               cmd;
        logic [SLOT_W-1:0]              slot;
        logic signed [ELEMENT_BITS-1:0] element;
        logic [RSQ_W-1:0]               radius_sq;
    } item_t;

    typedef struct packed {
        logic [RIDX_W-1:0]  radius_index;
        logic [COUNT_W-1:0] pair_count;
        logic [DIST_W-1:0]  min_dist_sq;
        logic [DIST_W-1:0]  max_dist_sq;
        logic               last;
    } result_t;

    typedef struct packed {
        logic              elem_we;
        logic              rad_we;
        logic              run_start;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_a;
        logic [ADDR_W-1:0] rd_b;
        logic              pair_start;
        logic              upd_minmax;
        logic              rad_rd;
        logic              hist_we;
        logic              hist_clr;
        logic              hist_rd;
        logic [RAD_W-1:0]  idx;
        logic              emit_ld;
        logic              emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic busy;
        logic hit;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: design/pdrc_ctrl.sv
// Controller of the pair walk: configuration registers, loop counters and sequencing.
`default_nettype none

module pdrc_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    input  wire logic [pdrc_pkg::CMD_W-1:0]       item_cmd,
    output logic                                  item_stall,
    input  wire logic                             cfg_we,
    input  wire logic [pdrc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pdrc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pdrc_pkg::ctrl_cmd_t                   cmd,
    input  wire pdrc_pkg::dp_status_t             status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DIST,
        S_DRAIN,
        S_RRD,
        S_RCMP,
        S_HRD,
        S_HWR,
        S_NEXT,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t state_reg;

    logic [pdrc_pkg::VC_W-1:0]     vc_reg;
    logic [pdrc_pkg::DIMCFG_W-1:0] dim_reg;
    logic [pdrc_pkg::RCCFG_W-1:0]  rc_reg;

    logic [pdrc_pkg::NV_W-1:0]   nv_reg;
    logic [pdrc_pkg::ND_W-1:0]   nd_reg;
    logic [pdrc_pkg::NR_W-1:0]   nr_reg;
    logic [pdrc_pkg::VEC_W-1:0]  i_reg;
    logic [pdrc_pkg::VEC_W-1:0]  j_reg;
    logic [pdrc_pkg::DIM_W-1:0]  k_reg;
    logic [pdrc_pkg::RAD_W-1:0]  r_reg;
    logic [pdrc_pkg::ADDR_W-1:0] base_i_reg;
    logic [pdrc_pkg::ADDR_W-1:0] base_j_reg;

    logic                        accept;
    logic [pdrc_pkg::NV_W-1:0]   nv_eff;
    logic [pdrc_pkg::ND_W-1:0]   nd_eff;
    logic [pdrc_pkg::NR_W-1:0]   nr_eff;
    logic                        r_last;
    logic                        k_last;
    logic                        j_more;
    logic                        i_more;
    logic [pdrc_pkg::ADDR_W-1:0] nd_ext;

    assign accept     = item_valid && (state_reg == S_IDLE);
    assign item_stall = (state_reg != S_IDLE);

    assign nv_eff = (vc_reg > pdrc_pkg::VC_W'(pdrc_pkg::MAX_VECTORS))
                  ? pdrc_pkg::NV_W'(pdrc_pkg::MAX_VECTORS) : pdrc_pkg::NV_W'(vc_reg);
    assign nd_eff = (dim_reg == '0) ? pdrc_pkg::ND_W'(1)
                  : (dim_reg > pdrc_pkg::DIMCFG_W'(pdrc_pkg::MAX_DIMS))
                  ? pdrc_pkg::ND_W'(pdrc_pkg::MAX_DIMS) : pdrc_pkg::ND_W'(dim_reg);
    assign nr_eff = (rc_reg == '0) ? pdrc_pkg::NR_W'(1)
                  : (rc_reg > pdrc_pkg::RCCFG_W'(pdrc_pkg::MAX_RADII))
                  ? pdrc_pkg::NR_W'(pdrc_pkg::MAX_RADII) : pdrc_pkg::NR_W'(rc_reg);

    assign nd_ext = pdrc_pkg::ADDR_W'(nd_reg);
    assign r_last = (pdrc_pkg::NR_W'(r_reg) + pdrc_pkg::NR_W'(1)) == nr_reg;
    assign k_last = (pdrc_pkg::ND_W'(k_reg) + pdrc_pkg::ND_W'(1)) == nd_reg;
    assign j_more = ({1'b0, j_reg} + (pdrc_pkg::VEC_W + 1)'(1)) < {1'b0, i_reg};
    assign i_more = (pdrc_pkg::NV_W'(i_reg) + pdrc_pkg::NV_W'(1)) < nv_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.elem_we    = accept && (item_cmd == pdrc_pkg::CMD_LOAD_ELEM);
        cmd.rad_we     = accept && (item_cmd == pdrc_pkg::CMD_LOAD_RADIUS);
        cmd.run_start  = accept && (item_cmd == pdrc_pkg::CMD_RUN);
        cmd.rd_en      = (state_reg == S_DIST);
        cmd.rd_a       = base_i_reg + pdrc_pkg::ADDR_W'(k_reg);
        cmd.rd_b       = base_j_reg + pdrc_pkg::ADDR_W'(k_reg);
        cmd.pair_start = (state_reg == S_DIST) && (k_reg == '0);
        cmd.upd_minmax = (state_reg == S_DRAIN) && !status.busy;
        cmd.rad_rd     = (state_reg == S_RRD);
        cmd.hist_we    = (state_reg == S_CLEAR) || (state_reg == S_HWR);
        cmd.hist_clr   = (state_reg == S_CLEAR);
        cmd.hist_rd    = (state_reg == S_HRD) || ((state_reg == S_EMIT_RD) && status.out_free);
        cmd.idx        = r_reg;
        cmd.emit_ld    = (state_reg == S_EMIT_LD);
        cmd.emit_last  = r_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg  <= pdrc_pkg::VC_W'(2);
            dim_reg <= pdrc_pkg::DIMCFG_W'(1);
            rc_reg  <= pdrc_pkg::RCCFG_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == pdrc_pkg::REG_VECTOR_COUNT)
            begin
                vc_reg <= pdrc_pkg::VC_W'(cfg_data);
            end
            if (cfg_index == pdrc_pkg::REG_DIMENSION)
            begin
                dim_reg <= pdrc_pkg::DIMCFG_W'(cfg_data);
            end
            if (cfg_index == pdrc_pkg::REG_RADIUS_COUNT)
            begin
                rc_reg <= pdrc_pkg::RCCFG_W'(cfg_data);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            nv_reg     <= '0;
            nd_reg     <= '0;
            nr_reg     <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            r_reg      <= '0;
            base_i_reg <= '0;
            base_j_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.run_start)
                    begin
                        nv_reg    <= nv_eff;
                        nd_reg    <= nd_eff;
                        nr_reg    <= nr_eff;
                        r_reg     <= '0;
                        state_reg <= S_CLEAR;
                    end
                end
                S_CLEAR:
                begin
                    if (r_last)
                    begin
                        r_reg <= '0;
                        if (nv_reg < pdrc_pkg::NV_W'(2))
                        begin
                            state_reg <= S_EMIT_RD;
                        end
                        else
                        begin
                            i_reg      <= pdrc_pkg::VEC_W'(1);
                            j_reg      <= '0;
                            k_reg      <= '0;
                            base_i_reg <= nd_ext;
                            base_j_reg <= '0;
                            state_reg  <= S_DIST;
                        end
                    end
                    else
                    begin
                        r_reg <= r_reg + pdrc_pkg::RAD_W'(1);
                    end
                end
                S_DIST:
                begin
                    if (k_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + pdrc_pkg::DIM_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (!status.busy)
                    begin
                        r_reg     <= '0;
                        state_reg <= S_RRD;
                    end
                end
                S_RRD:
                begin
                    state_reg <= S_RCMP;
                end
                S_RCMP:
                begin
                    if (status.hit)
                    begin
                        state_reg <= S_HRD;
                    end
                    else if (r_last)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        r_reg     <= r_reg + pdrc_pkg::RAD_W'(1);
                        state_reg <= S_RRD;
                    end
                end
                S_HRD:
                begin
                    state_reg <= S_HWR;
                end
                S_HWR:
                begin
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    k_reg <= '0;
                    if (j_more)
                    begin
                        j_reg      <= j_reg + pdrc_pkg::VEC_W'(1);
                        base_j_reg <= base_j_reg + nd_ext;
                        state_reg  <= S_DIST;
                    end
                    else if (i_more)
                    begin
                        i_reg      <= i_reg + pdrc_pkg::VEC_W'(1);
                        j_reg      <= '0;
                        base_i_reg <= base_i_reg + nd_ext;
                        base_j_reg <= '0;
                        state_reg  <= S_DIST;
                    end
                    else
                    begin
                        r_reg     <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= S_EMIT_LD;
                    end
                end
                S_EMIT_LD:
                begin
                    if (r_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        r_reg     <= r_reg + pdrc_pkg::RAD_W'(1);
                        state_reg <= S_EMIT_RD;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/pdrc_dpath.sv
// Datapath: element and radius stores, distance pipeline, histogram and result register.
`default_nettype none

module pdrc_dpath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pdrc_pkg::item_t       item,
    input  wire pdrc_pkg::ctrl_cmd_t   cmd,
    output pdrc_pkg::dp_status_t       status,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output pdrc_pkg::result_t          result
);

    logic signed [pdrc_pkg::ELEMENT_BITS-1:0] elem_mem [pdrc_pkg::STORE_DEPTH];
    logic [pdrc_pkg::RSQ_W-1:0]               rad_mem  [pdrc_pkg::MAX_RADII];
    logic [pdrc_pkg::COUNT_W-1:0]             hist_mem [pdrc_pkg::MAX_RADII];

    logic signed [pdrc_pkg::ELEMENT_BITS-1:0] ra_reg;
    logic signed [pdrc_pkg::ELEMENT_BITS-1:0] rb_reg;
    logic signed [pdrc_pkg::DIFF_W-1:0]       diff_reg;
    logic [pdrc_pkg::SQ_W-1:0]                sq_reg;
    logic [pdrc_pkg::DIST_W-1:0]              acc_reg;
    logic [pdrc_pkg::DIST_W-1:0]              acc_next;
    logic                                     v1_reg;
    logic                                     v2_reg;
    logic                                     v3_reg;
    logic [pdrc_pkg::RSQ_W-1:0]               rad_q_reg;
    logic [pdrc_pkg::COUNT_W-1:0]             hist_q_reg;
    logic [pdrc_pkg::COUNT_W-1:0]             hist_wdata;
    logic [pdrc_pkg::DIST_W-1:0]              min_reg;
    logic [pdrc_pkg::DIST_W-1:0]              max_reg;
    logic [pdrc_pkg::COUNT_W-1:0]             prefix_reg;
    logic [pdrc_pkg::COUNT_W:0]               prefix_sum;
    logic [pdrc_pkg::COUNT_W-1:0]             prefix_next;
    logic [pdrc_pkg::DIST_W:0]                acc_sum;
    logic                                     result_valid_reg;
    pdrc_pkg::result_t                        result_reg;

    assign acc_sum  = {1'b0, acc_reg} + (pdrc_pkg::DIST_W + 1)'(sq_reg);
    assign acc_next = acc_sum[pdrc_pkg::DIST_W] ? pdrc_pkg::DIST_MAX
                    : acc_sum[pdrc_pkg::DIST_W-1:0];

    assign hist_wdata = cmd.hist_clr ? '0
                      : (hist_q_reg == pdrc_pkg::COUNT_MAX) ? hist_q_reg
                      : hist_q_reg + pdrc_pkg::COUNT_W'(1);

    assign prefix_sum  = {1'b0, prefix_reg} + {1'b0, hist_q_reg};
    assign prefix_next = prefix_sum[pdrc_pkg::COUNT_W] ? pdrc_pkg::COUNT_MAX
                       : prefix_sum[pdrc_pkg::COUNT_W-1:0];

    assign status.busy     = v1_reg || v2_reg || v3_reg;
    assign status.hit      = pdrc_pkg::RSQ_W'(acc_reg) < rad_q_reg;
    assign status.out_free = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.elem_we && ({1'b0, item.slot} < (pdrc_pkg::SLOT_W + 1)'(pdrc_pkg::STORE_DEPTH)))
        begin
            elem_mem[item.slot[pdrc_pkg::ADDR_W-1:0]] <= item.element;
        end
        if (cmd.rd_en)
        begin
            ra_reg <= elem_mem[cmd.rd_a];
            rb_reg <= elem_mem[cmd.rd_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rad_we && (item.slot < pdrc_pkg::SLOT_W'(pdrc_pkg::MAX_RADII)))
        begin
            rad_mem[item.slot[pdrc_pkg::RAD_W-1:0]] <= item.radius_sq;
        end
        if (cmd.rad_rd)
        begin
            rad_q_reg <= rad_mem[cmd.idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_we)
        begin
            hist_mem[cmd.idx] <= hist_wdata;
        end
        if (cmd.hist_rd)
        begin
            hist_q_reg <= hist_mem[cmd.idx];
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= pdrc_pkg::DIFF_W'(ra_reg) - pdrc_pkg::DIFF_W'(rb_reg);
        sq_reg   <= pdrc_pkg::SQ_W'(diff_reg * diff_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            acc_reg          <= '0;
            min_reg          <= pdrc_pkg::DIST_MAX;
            max_reg          <= '0;
            prefix_reg       <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.pair_start)
            begin
                acc_reg <= '0;
            end
            else if (v3_reg)
            begin
                acc_reg <= acc_next;
            end
            if (cmd.run_start)
            begin
                min_reg    <= pdrc_pkg::DIST_MAX;
                max_reg    <= '0;
                prefix_reg <= '0;
            end
            else if (cmd.upd_minmax && (acc_reg != '0))
            begin
                if (acc_reg > max_reg)
                begin
                    max_reg <= acc_reg;
                end
                if (acc_reg < min_reg)
                begin
                    min_reg <= acc_reg;
                end
            end
            if (cmd.emit_ld)
            begin
                prefix_reg              <= prefix_next;
                result_valid_reg        <= 1'b1;
                result_reg.radius_index <= pdrc_pkg::RIDX_W'(cmd.idx);
                result_reg.pair_count   <= prefix_next;
                result_reg.min_dist_sq  <= min_reg;
                result_reg.max_dist_sq  <= max_reg;
                result_reg.last         <= cmd.emit_last;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/pairwise_distance_radius_counter_top.sv
// Top level of the pairwise distance radius counter.
//
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     pdrc_pkg::item_t
// result    out        result_valid / result_stall pdrc_pkg::result_t
// config    in         cfg_we                      cfg_index, cfg_data
//
// Load transfers do not leave the idle state. A run is accepted, clears the counts one radius
// at a time, then per pair streams one element pair per dimension through the distance
// pipeline, scans the radii in order until the first hit, updates that radius's count by a
// read-modify-write and steps on. The serial radius scan and the count update bound each pair.
// Reset clears control and result state only; stores and pipeline data are undefined until
// written. The item channel stalls for the whole run; each result waits for a free output.
`default_nettype none

module pairwise_distance_radius_counter_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire pdrc_pkg::item_t                  item,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output pdrc_pkg::result_t                     result,
    input  wire logic                             cfg_we,
    input  wire logic [pdrc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pdrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pdrc_pkg::ctrl_cmd_t  cmd;
    pdrc_pkg::dp_status_t status;

    pdrc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_cmd   (item.cmd),
        .item_stall (item_stall),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status)
    );

    pdrc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// File: bench/pdrc_checker.sv
// Checker that predicts the radius counts of every run and compares them with the result transfers.
module pdrc_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    input  wire logic                            item_stall,
    input  wire pdrc_pkg::item_t                 item,
    input  wire logic                            result_valid,
    input  wire logic                            result_stall,
    input  wire pdrc_pkg::result_t               result,
    input  wire logic                            cfg_we,
    input  wire logic [pdrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pdrc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                   fail_count,
    output int                                   results_pending
);

    logic signed [pdrc_pkg::ELEMENT_BITS-1:0] element_mem [pdrc_pkg::STORE_DEPTH];
    logic [pdrc_pkg::RSQ_W-1:0]               radius_mem [pdrc_pkg::MAX_RADII];
    logic [pdrc_pkg::VC_W-1:0]                vector_count_reg;
    logic [pdrc_pkg::DIMCFG_W-1:0]            dimension_reg;
    logic [pdrc_pkg::RCCFG_W-1:0]             radius_count_reg;
    pdrc_pkg::result_t                        expected_counts [$];

    task automatic tally_pairs();
        int                nv;
        int                nd;
        int                nr;
        longint unsigned   count [pdrc_pkg::MAX_RADII];
        longint unsigned   dist_sq;
        longint unsigned   dmin;
        longint unsigned   dmax;
        longint            diff;
        bit                hit;
        pdrc_pkg::result_t r;
        nv = (vector_count_reg > pdrc_pkg::MAX_VECTORS) ? pdrc_pkg::MAX_VECTORS
            : vector_count_reg;
        nd = (dimension_reg == 0) ? 1
            : ((dimension_reg > pdrc_pkg::MAX_DIMS) ? pdrc_pkg::MAX_DIMS : dimension_reg);
        nr = (radius_count_reg == 0) ? 1
            : ((radius_count_reg > pdrc_pkg::MAX_RADII) ? pdrc_pkg::MAX_RADII
            : radius_count_reg);
        foreach (count[k])
            count[k] = 0;
        dmin = pdrc_pkg::DIST_MAX;
        dmax = 0;
        for (int i = 1; i < nv; i++)
        begin
            for (int j = 0; j < i; j++)
            begin
                dist_sq = 0;
                for (int k = 0; k < nd; k++)
                begin
                    diff = longint'(element_mem[pdrc_pkg::ADDR_W'(i*nd+k)])
                         - longint'(element_mem[pdrc_pkg::ADDR_W'(j*nd+k)]);
                    if (diff < 0)
                        diff = -diff;
                    dist_sq += diff * diff;
                end
                if (dist_sq > pdrc_pkg::DIST_MAX)
                    dist_sq = pdrc_pkg::DIST_MAX;
                if (dist_sq > 0)
                begin
                    if (dist_sq > dmax)
                        dmax = dist_sq;
                    if (dist_sq < dmin)
                        dmin = dist_sq;
                end
                hit = 1'b0;
                for (int k = 0; k < nr; k++)
                begin
                    if (dist_sq < radius_mem[pdrc_pkg::RAD_W'(k)])
                        hit = 1'b1;
                    if (hit && count[k] < pdrc_pkg::COUNT_MAX)
                        count[k]++;
                end
            end
        end
        for (int k = 0; k < nr; k++)
        begin
            r.radius_index = k[pdrc_pkg::RIDX_W-1:0];
            r.pair_count   = count[k][pdrc_pkg::COUNT_W-1:0];
            r.min_dist_sq  = dmin[pdrc_pkg::DIST_W-1:0];
            r.max_dist_sq  = dmax[pdrc_pkg::DIST_W-1:0];
            r.last         = (k == nr - 1);
            expected_counts.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_count_reg = pdrc_pkg::VC_W'(2);
            dimension_reg    = pdrc_pkg::DIMCFG_W'(1);
            radius_count_reg = pdrc_pkg::RCCFG_W'(1);
            fail_count       = 0;
            expected_counts.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pdrc_pkg::REG_VECTOR_COUNT:
                        vector_count_reg = cfg_data[pdrc_pkg::VC_W-1:0];
                    pdrc_pkg::REG_DIMENSION:
                        dimension_reg    = cfg_data[pdrc_pkg::DIMCFG_W-1:0];
                    pdrc_pkg::REG_RADIUS_COUNT:
                        radius_count_reg = cfg_data[pdrc_pkg::RCCFG_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                case (item.cmd)
                    pdrc_pkg::CMD_LOAD_ELEM:
                        if (item.slot < pdrc_pkg::STORE_DEPTH)
                            element_mem[item.slot] = item.element;
                    pdrc_pkg::CMD_LOAD_RADIUS:
                        if (item.slot < pdrc_pkg::MAX_RADII)
                            radius_mem[item.slot[pdrc_pkg::RAD_W-1:0]] = item.radius_sq;
                    pdrc_pkg::CMD_RUN:
                        tally_pairs();
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (expected_counts.size() == 0)
                begin
                    $error("unexpected result transfer for radius %0d", result.radius_index);
                    fail_count++;
                end
                else
                begin
                    pdrc_pkg::result_t e;
                    e = expected_counts.pop_front();
                    if (result.radius_index !== e.radius_index)
                    begin
                        $error("radius_index expected %0d actual %0d",
                               e.radius_index, result.radius_index);
                        fail_count++;
                    end
                    if (result.pair_count !== e.pair_count)
                    begin
                        $error("pair_count expected %0d actual %0d", e.pair_count,
                               result.pair_count);
                        fail_count++;
                    end
                    if (result.min_dist_sq !== e.min_dist_sq)
                    begin
                        $error("min_dist_sq expected %0d actual %0d", e.min_dist_sq,
                               result.min_dist_sq);
                        fail_count++;
                    end
                    if (result.max_dist_sq !== e.max_dist_sq)
                    begin
                        $error("max_dist_sq expected %0d actual %0d", e.max_dist_sq,
                               result.max_dist_sq);
                        fail_count++;
                    end
                    if (result.last !== e.last)
                    begin
                        $error("last expected %0d actual %0d", e.last, result.last);
                        fail_count++;
                    end
                end
            end
        end
        results_pending = expected_counts.size();
    end

endmodule

// File: bench/tb.sv
// Top of the pairwise distance radius counter bench: stimulus, clock, reset and verdict.
module tb;

    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [pdrc_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    logic                            clk;
    logic                            rst_n;
    logic                            item_valid;
    logic                            item_stall;
    pdrc_pkg::item_t                 item;
    logic                            result_valid;
    logic                            result_stall;
    pdrc_pkg::result_t               result;
    logic                            cfg_we;
    logic [pdrc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pdrc_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              fail_count;
    int                              results_pending;
    int                              load_transfers;
    int                              cycles;
    bit                              calm;

    pairwise_distance_radius_counter_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pdrc_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        result_stall <= !calm && ($urandom_range(0, 99) < 25);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("pairwise_distance_radius_counter_top regression: fail");
            $finish;
        end
    end

    function automatic pdrc_pkg::item_t random_item();
        logic [95:0]     raw;
        pdrc_pkg::item_t it;
        raw = {$urandom(), $urandom(), $urandom()};
        it  = raw[$bits(pdrc_pkg::item_t)-1:0];
        return it;
    endfunction

    function automatic logic [pdrc_pkg::ELEMENT_BITS-1:0] pick_element();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2, 3, 4: return pdrc_pkg::ELEMENT_BITS'($urandom_range(0, 6) - 3);
            default: return pdrc_pkg::ELEMENT_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [pdrc_pkg::RSQ_W-1:0] pick_radius();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return raw[pdrc_pkg::RSQ_W-1:0] >> $urandom_range(0, pdrc_pkg::RSQ_W - 1);
        endcase
    endfunction

    task automatic send_item(input pdrc_pkg::item_t it);
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
    endtask

    task automatic send_noise();
        pdrc_pkg::item_t it;
        it = random_item();
        if ($urandom_range(0, 1))
            it.cmd = CMD_SPARE;
        else
        begin
            it.cmd  = pdrc_pkg::CMD_LOAD_RADIUS;
            it.slot = pdrc_pkg::SLOT_W'($urandom_range(pdrc_pkg::MAX_RADII,
                                                      2**pdrc_pkg::SLOT_W - 1));
        end
        send_item(it);
    endtask

    task automatic load_element(input int slot,
                                input logic [pdrc_pkg::ELEMENT_BITS-1:0] value);
        pdrc_pkg::item_t it;
        if ($urandom_range(0, 9) == 0)
            send_noise();
        it         = random_item();
        it.cmd     = pdrc_pkg::CMD_LOAD_ELEM;
        it.slot    = pdrc_pkg::SLOT_W'(slot);
        it.element = value;
        send_item(it);
        load_transfers++;
    endtask

    task automatic load_radius(input int slot, input logic [pdrc_pkg::RSQ_W-1:0] value);
        pdrc_pkg::item_t it;
        if ($urandom_range(0, 9) == 0)
            send_noise();
        it           = random_item();
        it.cmd       = pdrc_pkg::CMD_LOAD_RADIUS;
        it.slot      = pdrc_pkg::SLOT_W'(slot);
        it.radius_sq = value;
        send_item(it);
        load_transfers++;
    endtask

    task automatic start_run();
        pdrc_pkg::item_t it;
        it     = random_item();
        it.cmd = pdrc_pkg::CMD_RUN;
        send_item(it);
        load_transfers++;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_config(input int vc, input int dim, input int rc);
        cfg_we    <= 1'b1;
        cfg_index <= pdrc_pkg::REG_VECTOR_COUNT;
        cfg_data  <= pdrc_pkg::CFG_DATA_W'(vc);
        @(posedge clk);
        cfg_index <= pdrc_pkg::REG_DIMENSION;
        cfg_data  <= pdrc_pkg::CFG_DATA_W'(dim);
        @(posedge clk);
        cfg_index <= pdrc_pkg::REG_RADIUS_COUNT;
        cfg_data  <= pdrc_pkg::CFG_DATA_W'(rc);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int vc, input int dim, input int rc);
        int nd;
        int nr;
        nd = dim % 32;
        nd = (nd == 0) ? 1 : ((nd > pdrc_pkg::MAX_DIMS) ? pdrc_pkg::MAX_DIMS : nd);
        nr = rc % 128;
        nr = (nr == 0) ? 1 : ((nr > pdrc_pkg::MAX_RADII) ? pdrc_pkg::MAX_RADII : nr);
        write_config(vc, dim, rc);
        for (int s = 0; s < vc * nd; s++)
            load_element(s, pick_element());
        for (int s = 0; s < nr; s++)
            load_radius(s, pick_radius());
        start_run();
        if ($urandom_range(0, 1))
        begin
            if ($urandom_range(0, 2) == 0)
                wait_idle();
            repeat ($urandom_range(1, 3))
                load_radius($urandom_range(0, nr - 1), pick_radius());
            if (vc > 0)
                load_element($urandom_range(0, vc * nd - 1), pick_element());
            start_run();
        end
        wait_idle();
    endtask

    initial
    begin
        int nd;
        int dim;
        int rc;
        int phase;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        result_stall   = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = pdrc_pkg::REG_VECTOR_COUNT;
        cfg_data       = '0;
        cycles         = 0;
        calm           = 1'b0;
        load_transfers = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: two one-dimensional vectors at opposite extremes.
        load_element(0, 16'h8000);
        load_element(1, 16'h7fff);
        load_radius(0, '1);
        start_run();
        send_noise();
        send_noise();
        start_run();
        // Identical vectors give no nonzero distance, and a zero radius never hits.
        load_element(1, 16'h8000);
        load_radius(0, '0);
        start_run();
        wait_idle();
        // Zero and one vector give no pairs; zero dimension and radius count act as one.
        write_config(0, 0, 0);
        start_run();
        wait_idle();
        write_config(1, 0, 0);
        start_run();
        wait_idle();
        // Oversized dimension and radius count are capped; then the maxima themselves are run.
        run_phase(2, 31, 127);
        run_phase(3, 16, 64);

        phase = 0;
        while (load_transfers < 330)
        begin
            calm = (phase >= 3 && phase < 6);
            dim  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 4);
            nd   = dim % 32;
            nd   = (nd == 0) ? 1 : ((nd > pdrc_pkg::MAX_DIMS) ? pdrc_pkg::MAX_DIMS : nd);
            rc   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0)
                run_phase($urandom_range(0, 1), dim, rc);
            else
                run_phase($urandom_range(2, (24 / nd < 2) ? 2 : 24 / nd), dim, rc);
            phase++;
        end
        calm = 1'b0;
        wait_idle();

        if (fail_count == 0)
            $display("pairwise_distance_radius_counter_top regression: pass");
        else
            $display("pairwise_distance_radius_counter_top regression: fail");
        $finish;
    end

endmodule
